// ----- rtl/multi_button_press_debouncer_macros.svh -----
// Assertion macros for the button press debouncer checker.
`ifndef MULTI_BUTTON_PRESS_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_PRESS_DEBOUNCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbpd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MBPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbpd assertion failed");

`endif

// ----- rtl/mbpd_pkg.sv -----
// Shared types and constants of the button press debouncer.
package mbpd_pkg;

   localparam int TIME_W        = 32;
   localparam int LEVEL_BITS    = 16;
   localparam int COUNT_W       = 5;
   localparam int LOCKOUT_W     = 16;
   localparam int PRESS_INDEX_W = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 8;

   localparam logic [COUNT_W-1:0]   COUNT_RESET   = 5'd16;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT_MS   = 2'd1;

   // Priority token passed from cell to cell.
   typedef struct packed {
      logic                     found;
      logic [PRESS_INDEX_W-1:0] index;
   } mbpd_chain_type;

endpackage

// ----- rtl/mbpd_cell.sv -----
// One button cell: lockout timestamp, held mark and priority link.
module mbpd_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [mbpd_pkg::TIME_W-1:0]      now_ms,
   input  logic                             level,
   input  logic [mbpd_pkg::COUNT_W-1:0]     button_count,
   input  logic [mbpd_pkg::LOCKOUT_W-1:0]   lockout_ms,
   input  mbpd_pkg::mbpd_chain_type         chain_in,
   output mbpd_pkg::mbpd_chain_type         chain_out
);
   import mbpd_pkg::*;

   localparam bit IN_RANGE = (CELL_INDEX < LEVEL_BITS);
   localparam logic [COUNT_W-1:0]       CELL_POS = COUNT_W'(CELL_INDEX);
   localparam logic [PRESS_INDEX_W-1:0] CELL_IDX = PRESS_INDEX_W'(CELL_INDEX);

   logic [TIME_W-1:0] last_ff, last_in;
   logic              held_ff, held_in;
   logic [TIME_W-1:0] elapsed;
   logic              examined;
   logic              pressed;
   logic              fire;

   assign pressed  = ~level;
   // examined: inside the scan window and no earlier button fired
   assign examined = IN_RANGE && (button_count > CELL_POS) && !chain_in.found;
   assign elapsed  = now_ms - last_ff;
   assign fire     = examined && pressed && !held_ff
                     && (elapsed > {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_ms});

   always_comb begin
      last_in = last_ff;
      held_in = held_ff;
      if (take) begin
         if (fire) begin
            last_in = now_ms;
            held_in = 1'b1;
         end else if (examined && !pressed) begin
            held_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         held_ff <= 1'b0;
      end else begin
         last_ff <= last_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      chain_out = chain_in;
      if (fire) begin
         chain_out.found = 1'b1;
         chain_out.index = CELL_IDX;
      end
   end

endmodule

// ----- rtl/multi_button_press_debouncer.sv -----
// Top level of the button press debouncer: cell row, config and result register.
//
//  channel | dir | handshake              | contents
//  req     | in  | req_tvalid/req_tready  | tdata: now_ms[31:0], button_levels[47:32]
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: press_found[0], press_index[4:1]
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One scan per clock unless rsp stalls: every cell compares its elapsed time in
// parallel and a priority token ripples down the row of cells, all in the
// accepting cycle. The result appears in the rsp register in the cycle after acceptance.
// A stalled rsp word holds; req_tready stays high while it is being taken.
// Synchronous reset clears all timestamps and held marks at once; the
// block accepts its first word in the cycle after reset drops.
module multi_button_press_debouncer #(
   parameter int MAX_BUTTONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mbpd_pkg::REQ_DATA_W-1:0]     req_tdata,  // now_ms, button_levels
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbpd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // press_found, press_index, pad
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbpd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mbpd_pkg::*;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LOCKOUT_W-1:0] lockout_ff, lockout_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [PRESS_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic              take;
   logic [TIME_W-1:0] now_ms;
   logic [LEVEL_BITS-1:0] button_levels;
   logic [MAX_BUTTONS-1:0] cell_level;
   mbpd_chain_type    chain [0:MAX_BUTTONS];

   assign now_ms        = req_tdata[TIME_W-1:0];
   assign button_levels = req_tdata[TIME_W+LEVEL_BITS-1:TIME_W];

   // Input moves whenever the result register is empty or draining.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   // ---- configuration registers ----
   always_comb begin
      count_in   = count_ff;
      lockout_in = lockout_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BUTTON_COUNT: count_in   = csr_data[COUNT_W-1:0];
            CSR_LOCKOUT_MS:   lockout_in = csr_data[LOCKOUT_W-1:0];
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_RESET;
         lockout_ff <= LOCKOUT_RESET;
      end else begin
         count_ff   <= count_in;
         lockout_ff <= lockout_in;
      end
   end

   // ---- row of button cells, token enters empty at cell 0 ----
   assign chain[0] = '0;

   for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_cell
      // cells past the level field see a released button and stay out of the scan
      if (i < LEVEL_BITS) begin : g_lvl
         assign cell_level[i] = button_levels[i];
      end else begin : g_idle
         assign cell_level[i] = 1'b1;
      end

      mbpd_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .take         (take),
         .now_ms       (now_ms),
         .level        (cell_level[i]),
         .button_count (count_ff),
         .lockout_ms   (lockout_ff),
         .chain_in     (chain[i]),
         .chain_out    (chain[i+1])
      );
   end

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = chain[MAX_BUTTONS].found;
         rsp_index_in = chain[MAX_BUTTONS].index;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1-PRESS_INDEX_W){1'b0}}, rsp_index_ff, rsp_found_ff};

endmodule

// ----- rtl/mbpd_checker.sv -----
// Port-level checker for the button press debouncer, bound to the top level.
`include "multi_button_press_debouncer_macros.svh"

module mbpd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mbpd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mbpd_pkg::*;

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // stalled result word holds
   `MBPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // every accepted scan yields a result next cycle
   `MBPD_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_tvalid && req_tready, rsp_tvalid)
   // a stalled full result register blocks input
   `MBPD_ASSERT_SAME(a_backpressure, clock, reset, rsp_stall, !req_tready)
   // no press means index zero
   `MBPD_ASSERT_SAME(a_idle_index, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[4:1] == 4'd0)
   // padding bits stay zero
   `MBPD_ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:5] == 3'd0)

endmodule

bind multi_button_press_debouncer mbpd_checker u_mbpd_checker (.*);
